// ===== sv/bounded_stack_with_search_unit_assert.svh =====
// Assertion macros for the stack RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef BOUNDED_STACK_WITH_SEARCH_UNIT_ASSERT_SVH
`define BOUNDED_STACK_WITH_SEARCH_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BSS_ASSERT_IMPL(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("stack assertion failed");
`define BSS_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("stack assertion failed");
`else
`define BSS_ASSERT_IMPL(lbl, ant, cons)
`define BSS_ASSERT_NEXT(lbl, ant, cons)
`endif

`endif

// ===== sv/bss_pkg.sv =====
`default_nettype none
package bss_pkg;

    localparam int DEPTH  = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int DATA_W = 32;
    localparam int REQ_W  = 3;
    localparam int ST_W   = 3;
    localparam int POS_W  = 6;
    localparam int CAP_W  = 6;
    localparam int CMP_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [REQ_W-1:0]         req_t;
    typedef logic [ST_W-1:0]          status_t;
    typedef logic [POS_W-1:0]         pos_t;
    typedef logic [CAP_W-1:0]         cap_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [IDX_W-1:0]         idx_t;

    localparam cap_t CAP_RESET = 6'd32;

    localparam req_t REQ_PUSH   = 3'd0;
    localparam req_t REQ_POP    = 3'd1;
    localparam req_t REQ_DUMP   = 3'd2;
    localparam req_t REQ_SEARCH = 3'd3;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_OVERFLOW  = 3'd1;
    localparam status_t ST_UNDERFLOW = 3'd2;
    localparam status_t ST_EMPTY     = 3'd3;
    localparam status_t ST_FOUND     = 3'd4;
    localparam status_t ST_NOTFOUND  = 3'd5;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_PUSH = 2'd1,
        CELL_POP  = 2'd2,
        CELL_ROT  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     tail;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/bss_req_if.sv =====
`default_nettype none
interface bss_req_if;
    logic               valid;
    logic               ready;
    bss_pkg::req_t      req_type;
    bss_pkg::data_t     data_value;

    modport source (output valid, output req_type, output data_value, input ready);
    modport sink   (input valid, input req_type, input data_value, output ready);
endinterface
`default_nettype wire

// ===== sv/bss_rsp_if.sv =====
`default_nettype none
interface bss_rsp_if;
    logic               valid;
    logic               ready;
    bss_pkg::status_t   status;
    bss_pkg::data_t     value_out;
    bss_pkg::pos_t      position;
    logic               is_full;
    logic               is_empty;
    logic               last;

    modport source (output valid, output status, output value_out, output position,
                    output is_full, output is_empty, output last, input ready);
    modport sink   (input valid, input status, input value_out, input position,
                    input is_full, input is_empty, input last, output ready);
endinterface
`default_nettype wire

// ===== sv/bounded_stack_with_search_unit.sv =====
// Channel | Dir | Payload                                          | Transaction
// req     | in  | req_type, data_value                             | valid & ready
// rsp     | out | status, value_out, position, is_full, is_empty, last | valid & ready
// cfg     | in  | cfg_wdata (capacity)                             | cfg_we
//
// For push, pop and status, the result lands straight in the output register.
// Dump and search walk the stored entries past the head through the ring of cells,
// which rotates one entry per cycle unless a stalled output holds the walk.
// Reset clears the count and control state and sets the capacity to CAP_RESET; the cells hold no reset value.
// A stalled output holds a dump in place and holds a search at its final entry;
// a new request waits until the block is idle and the output register is free.
`default_nettype none
`include "bounded_stack_with_search_unit_assert.svh"
module bounded_stack_with_search_unit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    bss_req_if.sink                    req,
    bss_rsp_if.source                  rsp,
    input  wire logic                  cfg_we,
    input  wire bss_pkg::cap_t         cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DUMP   = 3'b010,
        S_SEARCH = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    bss_pkg::cnt_t       count_reg, count_next;
    bss_pkg::cap_t       cap_reg;
    bss_pkg::idx_t       step_reg, step_next;
    bss_pkg::data_t      key_reg, key_next;
    bss_pkg::pos_t       match_reg, match_next;
    logic                found_reg, found_next;

    logic                ov_reg;
    bss_pkg::status_t    o_status_reg;
    bss_pkg::data_t      o_value_reg;
    bss_pkg::pos_t       o_pos_reg;
    logic                o_full_reg, o_empty_reg, o_last_reg;

    logic                emit;
    bss_pkg::status_t    e_status;
    bss_pkg::data_t      e_value;
    bss_pkg::pos_t       e_pos;
    logic                e_last;

    bss_pkg::cell_op_t   cell_op;
    bss_pkg::data_t      cell_q [bss_pkg::DEPTH];
    bss_pkg::data_t      head;
    bss_pkg::cnt_t       eff_cap;
    logic                out_free, walk_last, full_now, hit;
    bss_pkg::pos_t       pos_now;
    bss_pkg::pos_t       new_match;

    assign head     = cell_q[0];
    assign out_free = !ov_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign walk_last = (bss_pkg::CNT_W'(step_reg) == count_reg - bss_pkg::CNT_W'(1));
    assign hit       = (head == key_reg);
    assign pos_now   = bss_pkg::POS_W'(count_reg - bss_pkg::CNT_W'(step_reg));
    assign new_match = hit ? pos_now : match_reg;

    // Zero acts as one, anything beyond the cell count acts as the cell count.
    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = bss_pkg::CNT_W'(1);
        else if (bss_pkg::CMP_W'(cap_reg) > bss_pkg::CMP_W'(bss_pkg::DEPTH))
            eff_cap = bss_pkg::CNT_W'(bss_pkg::DEPTH);
        else
            eff_cap = bss_pkg::CNT_W'(cap_reg);
    end

    assign full_now = (bss_pkg::CMP_W'(count_reg) >= bss_pkg::CMP_W'(eff_cap));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        step_next  = step_reg;
        key_next   = key_reg;
        match_next = match_reg;
        found_next = found_reg;
        cell_op    = bss_pkg::CELL_HOLD;
        emit       = 1'b0;
        e_status   = bss_pkg::ST_OK;
        e_value    = '0;
        e_pos      = '0;
        e_last     = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    case (req.req_type)
                        bss_pkg::REQ_PUSH:
                        begin
                            emit = 1'b1;
                            if (full_now)
                                e_status = bss_pkg::ST_OVERFLOW;
                            else
                            begin
                                cell_op    = bss_pkg::CELL_PUSH;
                                count_next = count_reg + bss_pkg::CNT_W'(1);
                            end
                        end
                        bss_pkg::REQ_POP:
                        begin
                            emit = 1'b1;
                            if (count_reg == '0)
                                e_status = bss_pkg::ST_UNDERFLOW;
                            else
                            begin
                                cell_op    = bss_pkg::CELL_POP;
                                e_value    = head;
                                count_next = count_reg - bss_pkg::CNT_W'(1);
                            end
                        end
                        bss_pkg::REQ_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                emit     = 1'b1;
                                e_status = bss_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DUMP;
                                step_next  = '0;
                            end
                        end
                        bss_pkg::REQ_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                emit     = 1'b1;
                                e_status = bss_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                                step_next  = '0;
                                key_next   = req.data_value;
                                match_next = '0;
                                found_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            emit     = 1'b1;
                            e_status = (count_reg == '0) ? bss_pkg::ST_EMPTY : bss_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    e_value   = head;
                    e_last    = walk_last;
                    cell_op   = bss_pkg::CELL_ROT;
                    step_next = step_reg + bss_pkg::IDX_W'(1);
                    if (walk_last)
                        state_next = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                // Entries pass the head top first, so a later hit is closer to the bottom.
                if (!walk_last)
                begin
                    cell_op    = bss_pkg::CELL_ROT;
                    step_next  = step_reg + bss_pkg::IDX_W'(1);
                    match_next = new_match;
                    found_next = found_reg || hit;
                end
                else if (out_free)
                begin
                    cell_op    = bss_pkg::CELL_ROT;
                    emit       = 1'b1;
                    e_status   = (found_reg || hit) ? bss_pkg::ST_FOUND : bss_pkg::ST_NOTFOUND;
                    e_pos      = (found_reg || hit) ? new_match : '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            cap_reg   <= bss_pkg::CAP_RESET;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (emit)
                ov_reg <= 1'b1;
            else if (rsp.ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        key_reg   <= key_next;
        match_reg <= match_next;
        found_reg <= found_next;
        if (emit)
        begin
            o_status_reg <= e_status;
            o_value_reg  <= e_value;
            o_pos_reg    <= e_pos;
            o_last_reg   <= e_last;
            o_full_reg   <= (bss_pkg::CMP_W'(count_next) >= bss_pkg::CMP_W'(eff_cap));
            o_empty_reg  <= (count_next == '0);
        end
    end

    assign rsp.valid     = ov_reg;
    assign rsp.status    = o_status_reg;
    assign rsp.value_out = o_value_reg;
    assign rsp.position  = o_pos_reg;
    assign rsp.is_full   = o_full_reg;
    assign rsp.is_empty  = o_empty_reg;
    assign rsp.last      = o_last_reg;

    // Cell 0 is the top of the stack.
    for (genvar k = 0; k < bss_pkg::DEPTH; k++)
    begin : g_cell
        bss_pkg::cell_ctrl_t ctrl;
        bss_pkg::data_t      above_d;
        bss_pkg::data_t      below_d;

        assign ctrl.op   = cell_op;
        assign ctrl.tail = (bss_pkg::CNT_W'(k) == count_reg - bss_pkg::CNT_W'(1));

        if (k == 0)
        begin : g_top
            assign above_d = req.data_value;
        end
        else
        begin : g_mid
            assign above_d = cell_q[k-1];
        end

        if (k == bss_pkg::DEPTH - 1)
        begin : g_bot
            assign below_d = '0;
        end
        else
        begin : g_inner
            assign below_d = cell_q[k+1];
        end

        bss_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .above_data (above_d),
            .below_data (below_d),
            .head_data  (head),
            .data       (cell_q[k])
        );
    end

    `BSS_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= bss_pkg::CNT_W'(bss_pkg::DEPTH))
    `BSS_ASSERT_IMPL(a_ready_idle, req.ready, state_reg == S_IDLE)
    `BSS_ASSERT_NEXT(a_walk_count, state_reg != S_IDLE, count_reg == $past(count_reg))
    `BSS_ASSERT_NEXT(a_dump_end, state_reg == S_DUMP && emit && walk_last, state_reg == S_IDLE)
    `BSS_ASSERT_IMPL(a_emit_free, emit, out_free)

endmodule
`default_nettype wire

// ===== sv/bss_cell.sv =====
`default_nettype none
module bss_cell (
    input  wire logic                clk,
    input  wire bss_pkg::cell_ctrl_t ctrl,
    input  wire bss_pkg::data_t      above_data,
    input  wire bss_pkg::data_t      below_data,
    input  wire bss_pkg::data_t      head_data,
    output bss_pkg::data_t           data
);

    bss_pkg::data_t data_reg;
    bss_pkg::data_t data_next;

    // The tail cell closes the ring during a walk so the stored entries come back in order.
    always_comb
    begin
        case (ctrl.op)
            bss_pkg::CELL_PUSH: data_next = above_data;
            bss_pkg::CELL_POP:  data_next = below_data;
            bss_pkg::CELL_ROT:  data_next = ctrl.tail ? head_data : below_data;
            default:            data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

// ===== dv/bounded_stack_with_search_unit_test.sv =====
`default_nettype none
module bounded_stack_with_search_unit_test;

    // Request codes the package leaves unnamed: the status query and the unused range.
    localparam bss_pkg::req_t REQ_STATUS    = 3'd4;
    localparam bss_pkg::req_t REQ_UNUSED_LO = 3'd5;
    localparam bss_pkg::req_t REQ_UNUSED_HI = 3'd7;

    localparam bss_pkg::data_t DATA_MAX = 32'sh7FFF_FFFF;
    localparam bss_pkg::data_t DATA_MIN = 32'sh8000_0000;

    localparam bss_pkg::cap_t CAP_ZERO = 6'd0;
    localparam bss_pkg::cap_t CAP_ONE  = 6'd1;
    localparam bss_pkg::cap_t CAP_TWO  = 6'd2;
    localparam bss_pkg::cap_t CAP_MAX  = 6'd63;

    // A dump or a search walks at most DEPTH entries.
    localparam int DRAIN_CYCLES = bss_pkg::DEPTH + 8;
    localparam int LONG_HOLD    = 150;
    localparam int RUN_LIMIT    = 400000;

    typedef struct {
        bss_pkg::status_t status;
        bss_pkg::data_t   value_out;
        bss_pkg::pos_t    position;
        logic             is_full;
        logic             is_empty;
        logic             last;
    } stack_result_t;

    typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

    class stack_mirror;
        bss_pkg::data_t entries [bss_pkg::DEPTH];
        int             fill;
        bss_pkg::cap_t  capacity;
        stack_result_t  awaited[$];
        int             n_errors;
        int             n_checked;

        function new();
            fill      = 0;
            capacity  = bss_pkg::CAP_RESET;
            n_errors  = 0;
            n_checked = 0;
        endfunction

        function int usable();
            if (capacity == 0)
                return 1;
            if (capacity > bss_pkg::DEPTH)
                return bss_pkg::DEPTH;
            return capacity;
        endfunction

        function void add_result(bss_pkg::status_t st, bss_pkg::data_t val, bss_pkg::pos_t pos,
                                 bit is_last);
            stack_result_t r;
            r.status    = st;
            r.value_out = val;
            r.position  = pos;
            r.is_full   = (fill >= usable());
            r.is_empty  = (fill == 0);
            r.last      = is_last;
            awaited.push_back(r);
        endfunction

        function void apply_request(bss_pkg::req_t kind, bss_pkg::data_t value);
            int hit;
            hit = 0;
            case (kind)
                bss_pkg::REQ_PUSH:
                    if (fill >= usable())
                        add_result(bss_pkg::ST_OVERFLOW, '0, '0, 1'b1);
                    else
                    begin
                        entries[fill] = value;
                        fill++;
                        add_result(bss_pkg::ST_OK, '0, '0, 1'b1);
                    end
                bss_pkg::REQ_POP:
                    if (fill == 0)
                        add_result(bss_pkg::ST_UNDERFLOW, '0, '0, 1'b1);
                    else
                    begin
                        fill--;
                        add_result(bss_pkg::ST_OK, entries[fill], '0, 1'b1);
                    end
                bss_pkg::REQ_DUMP:
                    if (fill == 0)
                        add_result(bss_pkg::ST_EMPTY, '0, '0, 1'b1);
                    else
                        for (int k = fill - 1; k >= 0; k--)
                            add_result(bss_pkg::ST_OK, entries[k], '0, k == 0);
                bss_pkg::REQ_SEARCH:
                begin
                    // The first match counted from the bottom wins.
                    for (int i = 0; i < fill && hit == 0; i++)
                        if (entries[i] == value)
                            hit = i + 1;
                    if (hit != 0)
                        add_result(bss_pkg::ST_FOUND, '0, bss_pkg::pos_t'(hit), 1'b1);
                    else
                        add_result(bss_pkg::ST_NOTFOUND, '0, '0, 1'b1);
                end
                default:
                    add_result((fill == 0) ? bss_pkg::ST_EMPTY : bss_pkg::ST_OK, '0, '0, 1'b1);
            endcase
        endfunction

        task report(string msg);
            n_errors++;
            $display("ERROR at result %0d: %s", n_checked, msg);
        endtask

        task compare_result(stack_result_t got);
            stack_result_t want;
            n_checked++;
            if (awaited.size() == 0)
            begin
                report("result arrived with nothing awaited");
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, wanted %0d", got.status, want.status));
            if (got.value_out !== want.value_out)
                report($sformatf("value_out %0d, wanted %0d", got.value_out, want.value_out));
            if (got.position !== want.position)
                report($sformatf("position %0d, wanted %0d", got.position, want.position));
            if (got.is_full !== want.is_full)
                report($sformatf("is_full %b, wanted %b", got.is_full, want.is_full));
            if (got.is_empty !== want.is_empty)
                report($sformatf("is_empty %b, wanted %b", got.is_empty, want.is_empty));
            if (got.last !== want.last)
                report($sformatf("last %b, wanted %b", got.last, want.last));
        endtask
    endclass

    bit            clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    bss_pkg::cap_t cfg_wdata = bss_pkg::CAP_RESET;
    bit            hold_output = 1'b0;
    bit            sender_gaps = 1'b1;
    int            burst_left = 0;
    int unsigned   cycle_count = 0;

    stack_mirror mirror = new();

    bss_req_if req_ch();
    bss_rsp_if rsp_ch();

    bounded_stack_with_search_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin : result_monitor
        stack_result_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status    = rsp_ch.status;
            got.value_out = rsp_ch.value_out;
            got.position  = rsp_ch.position;
            got.is_full   = rsp_ch.is_full;
            got.is_empty  = rsp_ch.is_empty;
            got.last      = rsp_ch.last;
            mirror.compare_result(got);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // The result side stalls on its own pattern, switching to a new random mode whenever the current one runs out.
    initial
    begin : result_receiver
        int unsigned mode_left;
        rx_mode_t    mode;
        mode_left = 0;
        mode = RX_ALWAYS;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                hold_output = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 80);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS: rsp_ch.ready <= 1'b1;
                    RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   rsp_ch.ready <= (mode_left % 4 != 0);
                endcase
            end
        end
    end

    task automatic send_request(input bss_pkg::req_t kind, input bss_pkg::data_t value);
        int gap;
        if (burst_left == 0)
        begin
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.data_value <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        mirror.apply_request(kind, value);
        burst_left--;
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (mirror.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(input bss_pkg::cap_t cap);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we <= 1'b0;
        mirror.capacity = cap;
    endtask

    task automatic random_requests(input int n_items, input int push_pct);
        int             pick;
        bss_pkg::req_t  kind;
        bss_pkg::data_t value;
        for (int n = 0; n < n_items; n++)
        begin
            case ($urandom_range(0, 9))
                0:       value = DATA_MAX;
                1:       value = DATA_MIN;
                2:       value = '0;
                3:       value = -1;
                default: value = $urandom;
            endcase
            if ($urandom_range(0, 99) < push_pct)
                kind = bss_pkg::REQ_PUSH;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    kind = bss_pkg::REQ_POP;
                else if (pick < 52)
                    kind = bss_pkg::REQ_DUMP;
                else if (pick < 82)
                begin
                    kind = bss_pkg::REQ_SEARCH;
                    // Mostly look for something that is stored, so that hits are common.
                    if (mirror.fill > 0 && $urandom_range(0, 2) != 0)
                        value = mirror.entries[$urandom_range(0, mirror.fill - 1)];
                end
                else if (pick < 92)
                    kind = REQ_STATUS;
                else
                    kind = bss_pkg::req_t'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
            end
            send_request(kind, value);
        end
    endtask

    initial
    begin
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_STATUS;
        req_ch.data_value = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty stack: every request that has a special answer when nothing is stored; then edge values are pushed.
        send_request(REQ_STATUS, '0);
        send_request(bss_pkg::REQ_POP, '0);
        send_request(bss_pkg::REQ_DUMP, '0);
        send_request(bss_pkg::REQ_SEARCH, '0);
        send_request(REQ_UNUSED_HI, '0);
        send_request(bss_pkg::REQ_PUSH, DATA_MAX);
        send_request(bss_pkg::REQ_PUSH, DATA_MIN);
        send_request(bss_pkg::REQ_PUSH, '0);
        send_request(bss_pkg::REQ_PUSH, -1);
        send_request(bss_pkg::REQ_PUSH, '0);
        // The duplicate zero must be found at its lower position.
        send_request(bss_pkg::REQ_SEARCH, '0);
        send_request(bss_pkg::REQ_SEARCH, DATA_MIN);
        send_request(bss_pkg::REQ_SEARCH, -1);
        send_request(bss_pkg::REQ_SEARCH, 32'sh1234_5678);
        send_request(bss_pkg::REQ_DUMP, '0);
        send_request(bss_pkg::REQ_POP, '0);
        send_request(REQ_STATUS, '0);
        send_request(REQ_UNUSED_LO, '0);
        drain_results();

        // Capacity dropped below the fill: the stack reads full until pops go below it.
        set_capacity(CAP_TWO);
        send_request(bss_pkg::REQ_PUSH, 32'sd77);
        send_request(REQ_STATUS, '0);
        send_request(bss_pkg::REQ_POP, '0);
        send_request(bss_pkg::REQ_POP, '0);
        send_request(bss_pkg::REQ_POP, '0);
        send_request(bss_pkg::REQ_PUSH, 32'sd55);
        send_request(bss_pkg::REQ_PUSH, 32'sd56);
        drain_results();

        // A capacity of zero behaves as one.
        set_capacity(CAP_ZERO);
        random_requests(15, 50);
        drain_results();

        // Capacity above the depth: mostly pushes, with a long output stall first.
        set_capacity(CAP_MAX);
        hold_output = 1'b1;
        random_requests(40, 75);
        drain_results();

        set_capacity(bss_pkg::cap_t'($urandom_range(CAP_ONE, bss_pkg::DEPTH - 1)));
        random_requests(25, 45);
        drain_results();

        sender_gaps = 1'b0;
        set_capacity(bss_pkg::CAP_RESET);
        random_requests(15, 35);
        drain_results();

        if (mirror.n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/bss_pkg.sv
sv/bss_req_if.sv
sv/bss_rsp_if.sv
sv/bss_cell.sv
sv/bounded_stack_with_search_unit.sv
dv/bounded_stack_with_search_unit_test.sv
